>>> src/bpa_pkg.sv
// ============================================================================
// bpa_pkg
// Shared constants, datapath commands, status and controller states for the
// buddy page allocator.
// ============================================================================
`default_nettype none

package bpa_pkg;

  localparam int MAX_ORD = 14;
  localparam int POOL    = 16384;
  localparam int PW      = $clog2(POOL);          // page index width
  localparam int LW      = PW + 1;                // link width, holds the empty marker
  localparam int CW      = 15;                    // page count width
  localparam int OW      = $clog2(MAX_ORD + 2);   // order counter width
  localparam int HW      = $clog2(MAX_ORD + 1);   // stored order / list index width
  localparam int XW      = CW + 2;                // range arithmetic width

  localparam logic [LW-1:0] NIL = LW'(POOL);

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_DISP,
    OP_SCAN_RD,
    OP_SCAN_NEXT,
    OP_REWIND,
    OP_RESV_CLR,
    OP_ADD_BLK,
    OP_PUSH_A,
    OP_PUSH_B,
    OP_ALC_STEP,
    OP_ALC_TAKE,
    OP_SPLIT,
    OP_UL_RD,
    OP_UL_LAT,
    OP_UL_A,
    OP_UL_B,
    OP_UL_C,
    OP_ANC_RD,
    OP_ANC_NEXT,
    OP_MRG_RD,
    OP_MRG_TAKE,
    OP_MRG_UP,
    OP_MRG_PUSH,
    OP_FIN_OK,
    OP_FIN_FAIL
  } dp_op_t;

  typedef struct packed {
    logic [1:0] act;
    logic       disp_fail;
    logic       clr_last;
    logic       scan_last;
    logic       rd_resv;
    logic       rd_fhead;
    logic       ord_eq_a;
    logic       ord_eq_o;
    logic       rem_zero;
    logic       k_over;
    logic       head_k_live;
    logic       split_more;
    logic       a_over;
    logic       mrg_stop;
    logic       out_busy;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_DISP,
    S_ADD_RD,
    S_ADD_CHK,
    S_ADD_REW,
    S_ADD_CLR,
    S_ADD_BLK,
    S_ADD_REM,
    S_ALC_FIND,
    S_ALC_SPLIT,
    S_FR_RD,
    S_FR_CHK,
    S_FR_ANC,
    S_FR_ANC_CHK,
    S_FR_MRG,
    S_FR_MRG_CHK,
    S_FR_MRG_UP,
    S_PUSH_A,
    S_PUSH_B,
    S_UL_RD,
    S_UL_LAT,
    S_UL_A,
    S_UL_B,
    S_UL_C,
    S_FIN_OK,
    S_FIN_FAIL
  } ctl_state_t;

endpackage

`default_nettype wire

>>> src/bpa_req_if.sv
// ============================================================================
// bpa_req_if
// Request channel: action, start page and page count with valid/ready.
// ============================================================================
`default_nettype none

interface bpa_req_if;
  import bpa_pkg::*;

  logic          valid;
  logic          ready;
  logic [1:0]    action;
  logic [PW-1:0] start_page;
  logic [CW-1:0] page_count;

  modport source (output valid, action, start_page, page_count, input ready);
  modport sink   (input valid, action, start_page, page_count, output ready);
endinterface

`default_nettype wire

>>> src/bpa_rsp_if.sv
// ============================================================================
// bpa_rsp_if
// Result channel: status, block, block size and free total with valid/ready.
// ============================================================================
`default_nettype none

interface bpa_rsp_if;
  import bpa_pkg::*;

  logic          valid;
  logic          ready;
  logic          ok;
  logic [PW-1:0] block_start;
  logic [CW-1:0] block_pages;
  logic [CW-1:0] total_free;

  modport source (output valid, ok, block_start, block_pages, total_free, input ready);
  modport sink   (input valid, ok, block_start, block_pages, total_free, output ready);
endinterface

`default_nettype wire

>>> src/bpa_dpath.sv
// ============================================================================
// bpa_dpath
// Allocator datapath: per-page memories, free list heads, free total,
// working registers and the result register.
// ============================================================================
`default_nettype none

module bpa_dpath (
  input  logic                    clk,
  input  logic                    rst,
  input  bpa_pkg::dp_op_t         op,
  output bpa_pkg::dp_stat_t       stat,
  input  logic [1:0]              action,
  input  logic [bpa_pkg::PW-1:0]  start_page,
  input  logic [bpa_pkg::CW-1:0]  page_count,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output logic                    ok,
  output logic [bpa_pkg::PW-1:0]  block_start,
  output logic [bpa_pkg::CW-1:0]  block_pages,
  output logic [bpa_pkg::CW-1:0]  total_free
);
  import bpa_pkg::*;

  function automatic logic [OW-1:0] round_order(input logic [CW-1:0] cnt);
    logic [OW-1:0] r;
    r = '0;
    for (int n = CW; n >= 0; n--) begin
      if ((XW'(1) << n) >= XW'(cnt)) r = OW'(n);
    end
    return r;
  endfunction

  function automatic logic [OW-1:0] blk_order(input logic [LW-1:0] cp,
                                              input logic [CW-1:0] rm);
    logic [OW-1:0] r;
    r = '0;
    for (int n = 1; n <= MAX_ORD; n++) begin
      if (XW'(rm) >= (XW'(1) << n) && (XW'(cp) & ((XW'(1) << n) - XW'(1))) == '0)
        r = OW'(n);
    end
    return r;
  endfunction

  // per-page memories
  logic          resv_mem  [POOL];
  logic          fhead_mem [POOL];
  logic [HW-1:0] ord_mem   [POOL];
  logic [LW-1:0] nxt_mem   [POOL];
  logic [LW-1:0] prv_mem   [POOL];

  logic          rd_resv, rd_fhead;
  logic [HW-1:0] rd_ord;
  logic [LW-1:0] rd_nxt, rd_prv;

  logic [PW-1:0] maddr;
  logic          we_resv, we_fhead, we_ord, we_nxt, we_prv;
  logic          wd_resv, wd_fhead;
  logic [LW-1:0] wd_nxt, wd_prv;

  // control registers
  logic [LW-1:0] heads [MAX_ORD+1];
  logic [CW-1:0] free_sum;
  logic [LW-1:0] i;

  // working registers
  logic [1:0]    act;
  logic [PW-1:0] s;
  logic [CW-1:0] c;
  logic [OW-1:0] o, k, a, po;
  logic [LW-1:0] end_i, cur;
  logic [CW-1:0] rem;
  logic [PW-1:0] p, pp, up, idx, bud;
  logic [LW-1:0] h;
  logic [HW-1:0] un_o;
  logic [LW-1:0] un_n, un_pr;

  logic [OW-1:0] ro, bo;
  logic [XW-1:0] sz, sx, cx, anc_mask, bud_x;
  logic [PW-1:0] anc;
  logic [LW-1:0] heads_k, heads_po, end_val;
  logic          disp_fail;

  always_comb begin
    ro       = round_order(c);
    bo       = blk_order(cur, rem);
    sz       = XW'(1) << ro;
    sx       = XW'(s);
    cx       = XW'(c);
    anc_mask = ~((XW'(1) << a) - XW'(1));
    anc      = s & anc_mask[PW-1:0];
    bud_x    = XW'(idx) ^ (XW'(1) << o);
    heads_k  = (k > OW'(MAX_ORD)) ? NIL : heads[k[HW-1:0]];
    heads_po = heads[po[HW-1:0]];
    end_val  = (act == ACT_ADD) ? LW'(sx + cx) : LW'(sx + sz);
    case (act)
      ACT_ADD:   disp_fail = (c == '0) || (sx + cx > XW'(POOL));
      ACT_ALLOC: disp_fail = (c == '0) || (ro > OW'(MAX_ORD));
      ACT_FREE:  disp_fail = (c == '0) || (ro > OW'(MAX_ORD)) ||
                             ((sx & (sz - XW'(1))) != '0) || (sx + sz > XW'(POOL));
      default:   disp_fail = 1'b1;
    endcase
  end

  always_comb begin
    stat.act         = act;
    stat.disp_fail   = disp_fail;
    stat.clr_last    = (i == LW'(POOL - 1));
    stat.scan_last   = ((i + LW'(1)) == end_i);
    stat.rd_resv     = rd_resv;
    stat.rd_fhead    = rd_fhead;
    stat.ord_eq_a    = (OW'(rd_ord) == a);
    stat.ord_eq_o    = (OW'(rd_ord) == o);
    stat.rem_zero    = (rem == '0);
    stat.k_over      = (k > OW'(MAX_ORD));
    stat.head_k_live = (heads_k != NIL);
    stat.split_more  = (k > o);
    stat.a_over      = (a > OW'(MAX_ORD));
    stat.mrg_stop    = (o >= OW'(MAX_ORD)) || (bud_x >= XW'(POOL));
    stat.out_busy    = rsp_valid && !rsp_ready;
  end

  always_comb begin
    maddr    = i[PW-1:0];
    we_resv  = 1'b0;
    we_fhead = 1'b0;
    we_ord   = 1'b0;
    we_nxt   = 1'b0;
    we_prv   = 1'b0;
    wd_resv  = 1'b0;
    wd_fhead = 1'b0;
    wd_nxt   = heads_po;
    wd_prv   = NIL;
    case (op)
      OP_CLR: begin
        we_resv  = 1'b1;
        wd_resv  = 1'b1;
        we_fhead = 1'b1;
      end
      OP_RESV_CLR: we_resv = 1'b1;
      OP_PUSH_A: begin
        maddr    = pp;
        we_fhead = 1'b1;
        wd_fhead = 1'b1;
        we_ord   = 1'b1;
        we_nxt   = 1'b1;
        we_prv   = 1'b1;
      end
      OP_PUSH_B: begin
        maddr  = h[PW-1:0];
        we_prv = (h != NIL);
        wd_prv = LW'(pp);
      end
      OP_UL_RD: maddr = up;
      OP_UL_A: begin
        maddr  = un_pr[PW-1:0];
        we_nxt = (un_pr != NIL);
        wd_nxt = un_n;
      end
      OP_UL_B: begin
        maddr  = un_n[PW-1:0];
        we_prv = (un_n != NIL);
        wd_prv = un_pr;
      end
      OP_UL_C: begin
        maddr    = up;
        we_fhead = 1'b1;
      end
      OP_ANC_RD: maddr = anc;
      OP_MRG_RD: maddr = bud_x[PW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_resv) resv_mem[maddr] <= wd_resv;
    rd_resv <= resv_mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (we_fhead) fhead_mem[maddr] <= wd_fhead;
    rd_fhead <= fhead_mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (we_ord) ord_mem[maddr] <= HW'(po);
    rd_ord <= ord_mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (we_nxt) nxt_mem[maddr] <= wd_nxt;
    rd_nxt <= nxt_mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (we_prv) prv_mem[maddr] <= wd_prv;
    rd_prv <= prv_mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n <= MAX_ORD; n++) heads[n] <= NIL;
      free_sum  <= '0;
      i         <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (op == OP_FIN_OK || op == OP_FIN_FAIL) rsp_valid <= 1'b1;
      else if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      case (op)
        OP_CLR, OP_SCAN_NEXT, OP_RESV_CLR: i <= i + LW'(1);
        OP_DISP, OP_REWIND: i <= LW'(s);
        OP_PUSH_A: begin
          heads[po[HW-1:0]] <= LW'(pp);
          free_sum          <= free_sum + (CW'(1) << po);
        end
        OP_UL_A: begin
          if (un_pr == NIL && un_o <= HW'(MAX_ORD)) heads[un_o] <= un_n;
        end
        OP_UL_C: free_sum <= free_sum - (CW'(1) << un_o);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        act <= action;
        s   <= start_page;
        c   <= page_count;
      end
      OP_DISP: begin
        o     <= ro;
        k     <= ro;
        a     <= ro + OW'(1);
        end_i <= end_val;
        cur   <= LW'(s);
        rem   <= c;
        idx   <= s;
      end
      OP_ADD_BLK: begin
        po  <= bo;
        pp  <= cur[PW-1:0];
        cur <= cur + (LW'(1) << bo);
        rem <= rem - (CW'(1) << bo);
      end
      OP_PUSH_A: h <= heads_po;
      OP_ALC_STEP: k <= k + OW'(1);
      OP_ALC_TAKE: begin
        p  <= heads_k[PW-1:0];
        up <= heads_k[PW-1:0];
      end
      OP_SPLIT: begin
        k  <= k - OW'(1);
        po <= k - OW'(1);
        pp <= p + (PW'(1) << (k - OW'(1)));
      end
      OP_UL_LAT: begin
        un_o  <= rd_ord;
        un_n  <= rd_nxt;
        un_pr <= rd_prv;
      end
      OP_ANC_NEXT: a <= a + OW'(1);
      OP_MRG_RD: bud <= bud_x[PW-1:0];
      OP_MRG_TAKE: up <= bud;
      OP_MRG_UP: begin
        if (bud < idx) idx <= bud;
        o <= o + OW'(1);
      end
      OP_MRG_PUSH: begin
        pp <= idx;
        po <= o;
      end
      OP_FIN_OK: begin
        ok         <= 1'b1;
        total_free <= free_sum;
        if (act == ACT_ALLOC) begin
          block_start <= p;
          block_pages <= CW'(1) << o;
        end else if (act == ACT_FREE) begin
          block_start <= idx;
          block_pages <= CW'(1) << o;
        end else begin
          block_start <= '0;
          block_pages <= '0;
        end
      end
      OP_FIN_FAIL: begin
        ok          <= 1'b0;
        block_start <= '0;
        block_pages <= '0;
        total_free  <= free_sum;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> src/bpa_ctrl.sv
// ============================================================================
// bpa_ctrl
// Allocator sequencer: clear pass, request decode, range scans, list push
// and unlink subroutines, split and merge walks, result hand-off.
// ============================================================================
`default_nettype none

module bpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output bpa_pkg::dp_op_t   op,
  input  bpa_pkg::dp_stat_t stat
);
  import bpa_pkg::*;

  ctl_state_t state, state_next;
  ctl_state_t ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    op         = OP_NONE;
    req_ready  = (state == S_IDLE);
    unique case (state)
      S_CLR: begin
        op = OP_CLR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          op         = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        op = OP_DISP;
        if (stat.disp_fail) state_next = S_FIN_FAIL;
        else if (stat.act == ACT_ADD) state_next = S_ADD_RD;
        else if (stat.act == ACT_ALLOC) state_next = S_ALC_FIND;
        else state_next = S_FR_RD;
      end
      S_ADD_RD: begin
        op         = OP_SCAN_RD;
        state_next = S_ADD_CHK;
      end
      S_ADD_CHK: begin
        if (!stat.rd_resv) state_next = S_FIN_FAIL;
        else if (stat.scan_last) state_next = S_ADD_REW;
        else begin
          op         = OP_SCAN_NEXT;
          state_next = S_ADD_RD;
        end
      end
      S_ADD_REW: begin
        op         = OP_REWIND;
        state_next = S_ADD_CLR;
      end
      S_ADD_CLR: begin
        op = OP_RESV_CLR;
        if (stat.scan_last) state_next = S_ADD_BLK;
      end
      S_ADD_BLK: begin
        op         = OP_ADD_BLK;
        ret_next   = S_ADD_REM;
        state_next = S_PUSH_A;
      end
      S_ADD_REM: begin
        state_next = stat.rem_zero ? S_FIN_OK : S_ADD_BLK;
      end
      S_ALC_FIND: begin
        if (stat.k_over) state_next = S_FIN_FAIL;
        else if (stat.head_k_live) begin
          op         = OP_ALC_TAKE;
          ret_next   = S_ALC_SPLIT;
          state_next = S_UL_RD;
        end else op = OP_ALC_STEP;
      end
      S_ALC_SPLIT: begin
        if (stat.split_more) begin
          op         = OP_SPLIT;
          ret_next   = S_ALC_SPLIT;
          state_next = S_PUSH_A;
        end else state_next = S_FIN_OK;
      end
      S_FR_RD: begin
        op         = OP_SCAN_RD;
        state_next = S_FR_CHK;
      end
      S_FR_CHK: begin
        if (stat.rd_resv || stat.rd_fhead) state_next = S_FIN_FAIL;
        else if (stat.scan_last) state_next = S_FR_ANC;
        else begin
          op         = OP_SCAN_NEXT;
          state_next = S_FR_RD;
        end
      end
      S_FR_ANC: begin
        if (stat.a_over) state_next = S_FR_MRG;
        else begin
          op         = OP_ANC_RD;
          state_next = S_FR_ANC_CHK;
        end
      end
      S_FR_ANC_CHK: begin
        if (stat.rd_fhead && stat.ord_eq_a) state_next = S_FIN_FAIL;
        else begin
          op         = OP_ANC_NEXT;
          state_next = S_FR_ANC;
        end
      end
      S_FR_MRG: begin
        if (stat.mrg_stop) begin
          op         = OP_MRG_PUSH;
          ret_next   = S_FIN_OK;
          state_next = S_PUSH_A;
        end else begin
          op         = OP_MRG_RD;
          state_next = S_FR_MRG_CHK;
        end
      end
      S_FR_MRG_CHK: begin
        if (stat.rd_resv || !stat.rd_fhead || !stat.ord_eq_o) begin
          op         = OP_MRG_PUSH;
          ret_next   = S_FIN_OK;
          state_next = S_PUSH_A;
        end else begin
          op         = OP_MRG_TAKE;
          ret_next   = S_FR_MRG_UP;
          state_next = S_UL_RD;
        end
      end
      S_FR_MRG_UP: begin
        op         = OP_MRG_UP;
        state_next = S_FR_MRG;
      end
      S_PUSH_A: begin
        op         = OP_PUSH_A;
        state_next = S_PUSH_B;
      end
      S_PUSH_B: begin
        op         = OP_PUSH_B;
        state_next = ret;
      end
      S_UL_RD: begin
        op         = OP_UL_RD;
        state_next = S_UL_LAT;
      end
      S_UL_LAT: begin
        op         = OP_UL_LAT;
        state_next = S_UL_A;
      end
      S_UL_A: begin
        op         = OP_UL_A;
        state_next = S_UL_B;
      end
      S_UL_B: begin
        op         = OP_UL_B;
        state_next = S_UL_C;
      end
      S_UL_C: begin
        op         = OP_UL_C;
        state_next = ret;
      end
      S_FIN_OK: begin
        if (!stat.out_busy) begin
          op         = OP_FIN_OK;
          state_next = S_IDLE;
        end
      end
      S_FIN_FAIL: begin
        if (!stat.out_busy) begin
          op         = OP_FIN_FAIL;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> src/buddy_page_allocator_core.sv
// ============================================================================
// buddy_page_allocator_core
// Buddy page allocator over a 16384-page pool with one LIFO free list per
// order; add region, allocate and free requests, one result each.
//
//   channel  dir  payload
//   req      in   action, start_page, page_count
//   rsp      out  ok, block_start, block_pages, total_free
//
// After reset a clear pass marks every page reserved; no request is taken
// until it ends. Each request runs as a sequence over the single-port page
// memories: add scans and clears its range, then pushes blocks; allocate
// searches orders, then splits; free scans the block, checks each ancestor
// order, then merges. A waiting result holds in the output register while the
// next request is taken; the sequencer stalls only when it must hand off.
// ============================================================================
`default_nettype none

module buddy_page_allocator_core (
  input logic       clk,
  input logic       rst,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp
);
  import bpa_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .op        (op),
    .stat      (stat)
  );

  bpa_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .stat        (stat),
    .action      (req.action),
    .start_page  (req.start_page),
    .page_count  (req.page_count),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .ok          (rsp.ok),
    .block_start (rsp.block_start),
    .block_pages (rsp.block_pages),
    .total_free  (rsp.total_free)
  );

endmodule

`default_nettype wire

>>> dv/bpa_checker.sv
// ============================================================================
// bpa_checker
// Watches the request and result channels of the buddy page allocator. It
// keeps its own copy of the page pool and free lists, works out the result
// of every accepted request and compares each result field by field.
// ============================================================================
`timescale 1ns / 1ps

module bpa_checker
  import bpa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bpa_req_if   req,
  bpa_rsp_if   rsp,
  output int   fails,
  output int   pending
);

  typedef struct packed {
    logic          ok;
    logic [PW-1:0] block_start;
    logic [CW-1:0] block_pages;
    logic [CW-1:0] total_free;
  } alloc_result_t;

  alloc_result_t result_q[$];

  bit            reserved[POOL];
  bit            free_head[POOL];
  logic [3:0]    blk_order[POOL];
  logic [LW-1:0] nxt[POOL];
  logic [LW-1:0] prv[POOL];
  logic [LW-1:0] list_head[MAX_ORD+1];
  int            list_len[MAX_ORD+1];
  int            pool_free;

  initial begin
    fails = 0;
    pending = 0;
    pool_free = 0;
    for (int i = 0; i < POOL; i++) begin
      reserved[i] = 1'b1;
      free_head[i] = 1'b0;
      blk_order[i] = '0;
      nxt[i] = '0;
      prv[i] = '0;
    end
    for (int o = 0; o <= MAX_ORD; o++) begin
      list_head[o] = NIL;
      list_len[o] = 0;
    end
  end

  task automatic push_block(int o, int p);
    logic [LW-1:0] h;
    h = list_head[o];
    prv[p] = NIL;
    nxt[p] = h;
    if (h != NIL) prv[h] = LW'(p);
    list_head[o] = LW'(p);
    free_head[p] = 1'b1;
    blk_order[p] = 4'(o);
    list_len[o]++;
    pool_free += (1 << o);
  endtask

  task automatic unlink_block(int p);
    int o;
    logic [LW-1:0] n, pr;
    o = blk_order[p];
    n = nxt[p];
    pr = prv[p];
    if (o <= MAX_ORD) begin
      if (pr == NIL) list_head[o] = n;
      else nxt[pr] = n;
      if (n != NIL) prv[n] = pr;
      free_head[p] = 1'b0;
      list_len[o]--;
      pool_free -= (1 << o);
    end
  endtask

  function automatic int order_of(int c);
    int o;
    o = 0;
    while (o < 63 && (1 << o) < c) o++;
    return o;
  endfunction

  task automatic carve_region(int s, int c, output bit ok);
    int cur, rem, o;
    ok = 1'b0;
    if (c == 0 || s + c > POOL) return;
    for (int i = s; i < s + c; i++)
      if (!reserved[i]) return;
    for (int i = s; i < s + c; i++) reserved[i] = 1'b0;
    cur = s;
    rem = c;
    while (rem > 0) begin
      o = MAX_ORD;
      while (o > 0) begin
        if (rem >= (1 << o) && (cur & ((1 << o) - 1)) == 0) break;
        o--;
      end
      push_block(o, cur);
      cur += (1 << o);
      rem -= (1 << o);
    end
    ok = 1'b1;
  endtask

  task automatic take_block(int c, output bit ok, output int bs, output int bp);
    int o, k, p;
    ok = 1'b0;
    bs = 0;
    bp = 0;
    if (c == 0) return;
    o = order_of(c);
    if (o > MAX_ORD) return;
    for (k = o; k <= MAX_ORD; k++)
      if (list_head[k] != NIL) break;
    if (k > MAX_ORD) return;
    p = list_head[k];
    unlink_block(p);
    while (k > o) begin
      k--;
      push_block(k, p + (1 << k));
    end
    bs = p;
    bp = 1 << o;
    ok = 1'b1;
  endtask

  task automatic return_block(int s, int c, output bit ok, output int bs, output int bp);
    int o, sz, b, idx;
    ok = 1'b0;
    bs = 0;
    bp = 0;
    if (c == 0) return;
    o = order_of(c);
    if (o > MAX_ORD) return;
    sz = 1 << o;
    if ((s & (sz - 1)) != 0 || s + sz > POOL) return;
    for (int i = s; i < s + sz; i++)
      if (reserved[i] || free_head[i]) return;
    for (int a = o + 1; a <= MAX_ORD; a++) begin
      b = s & ~((1 << a) - 1);
      if (free_head[b] && blk_order[b] == a) return;
    end
    idx = s;
    while (o < MAX_ORD) begin
      b = idx ^ (1 << o);
      if (b >= POOL) break;
      if (reserved[b] || !free_head[b] || blk_order[b] != o) break;
      unlink_block(b);
      if (b < idx) idx = b;
      o++;
    end
    push_block(o, idx);
    bs = idx;
    bp = 1 << o;
    ok = 1'b1;
  endtask

  task automatic predict_request(logic [1:0] act, int s, int c);
    alloc_result_t r;
    bit ok;
    int bs, bp;
    ok = 1'b0;
    bs = 0;
    bp = 0;
    case (act)
      ACT_ADD:   carve_region(s, c, ok);
      ACT_ALLOC: take_block(c, ok, bs, bp);
      ACT_FREE:  return_block(s, c, ok, bs, bp);
      default:   ok = 1'b0;
    endcase
    if (!ok) begin
      bs = 0;
      bp = 0;
    end
    r.ok = ok;
    r.block_start = PW'(bs);
    r.block_pages = CW'(bp);
    r.total_free = CW'(pool_free);
    result_q.push_back(r);
  endtask

  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst) begin
      if (req.valid && req.ready)
        predict_request(req.action, int'(req.start_page), int'(req.page_count));
      if (rsp.valid && rsp.ready) begin
        if (result_q.size() == 0) begin
          $display("%0t unexpected result ok=%0b start=%0d pages=%0d free=%0d", $time,
                   rsp.ok, rsp.block_start, rsp.block_pages, rsp.total_free);
          fails++;
        end else begin
          e = result_q.pop_front();
          if (rsp.ok !== e.ok) begin
            $display("%0t ok mismatch: exp %0b got %0b", $time, e.ok, rsp.ok);
            fails++;
          end
          if (rsp.block_start !== e.block_start) begin
            $display("%0t block_start mismatch: exp %0d got %0d", $time,
                     e.block_start, rsp.block_start);
            fails++;
          end
          if (rsp.block_pages !== e.block_pages) begin
            $display("%0t block_pages mismatch: exp %0d got %0d", $time,
                     e.block_pages, rsp.block_pages);
            fails++;
          end
          if (rsp.total_free !== e.total_free) begin
            $display("%0t total_free mismatch: exp %0d got %0d", $time,
                     e.total_free, rsp.total_free);
            fails++;
          end
        end
      end
      pending <= result_q.size();
    end
  end

endmodule

>>> dv/testbench.sv
// ============================================================================
// testbench
// Drives add, allocate and free requests into the buddy page allocator with
// bursty requests and a stalling result side; the checker predicts and
// compares every result. Frees mostly target blocks handed out earlier.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
  import bpa_pkg::*;

  localparam int LIMIT = 10000000;
  localparam int N_RAND = 700;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bpa_req_if req_ch();
  bpa_rsp_if rsp_ch();

  int fails, pending;
  int cycles = 0;
  int burst_left = 0;
  int add_ptr = 1024;
  logic [1:0] sent_act_q[$];
  logic [PW+CW-1:0] live_blocks[$];

  buddy_page_allocator_core dut (.clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch));
  bpa_checker chk (.clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
                   .fails(fails), .pending(pending));

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side stall pattern, re-picked among always ready, half ready and rarely ready
  int stall_mode = 0;
  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       rsp_ch.ready <= 1'b1;
      1:       rsp_ch.ready <= $urandom_range(0, 1);
      default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // track handed-out blocks for meaningful frees
  always @(posedge clk) begin
    logic [1:0] a;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) sent_act_q.push_back(req_ch.action);
      if (rsp_ch.valid && rsp_ch.ready && sent_act_q.size() > 0) begin
        a = sent_act_q.pop_front();
        if (a == ACT_ALLOC && rsp_ch.ok)
          live_blocks.push_back({rsp_ch.block_start, rsp_ch.block_pages});
      end
    end
  end

  task automatic send_req(logic [1:0] act, int s, int c);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= act;
    req_ch.start_page <= PW'(s);
    req_ch.page_count <= CW'(c);
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain;
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int r, c, s, k;
    logic [PW+CW-1:0] blk;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_ADD;
    req_ch.start_page = '0;
    req_ch.page_count = '0;
    rsp_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send_req(ACT_ADD, 0, 1024);
    send_req(ACT_ADD, 16000, 383);
    send_req(ACT_ADD, 16383, 1);
    send_req(ACT_ADD, 100, 0);
    send_req(ACT_ADD, 16380, 10);
    send_req(ACT_ADD, 10, 5);
    send_req(2'd3, 16383, 32767);
    send_req(ACT_ALLOC, 0, 0);
    send_req(ACT_ALLOC, 0, 20000);
    send_req(ACT_ALLOC, 0, 1);
    send_req(ACT_ALLOC, 0, 3);
    send_req(ACT_ALLOC, 0, 16384);
    send_req(ACT_ALLOC, 0, 256);
    send_req(ACT_FREE, 1, 2);
    send_req(ACT_FREE, 16382, 4);
    send_req(ACT_FREE, 8192, 16384);
    send_req(ACT_FREE, 512, 1);
    send_req(ACT_FREE, 2000, 1);
    send_req(ACT_FREE, 0, 0);
    send_req(ACT_FREE, 0, 20000);
    drain();
    while (live_blocks.size() > 0) begin
      blk = live_blocks.pop_front();
      send_req(ACT_FREE, int'(blk[PW+CW-1:CW]), int'(blk[CW-1:0]));
    end
    drain();

    // random
    for (int i = 0; i < N_RAND; i++) begin
      if (i == N_RAND / 2) drain();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        k = $urandom_range(0, 99);
        c = k < 88 ? $urandom_range(1, 16) : k < 98 ? $urandom_range(1, 256)
                                                     : $urandom_range(1, 4096);
        send_req(ACT_ALLOC, $urandom_range(0, POOL - 1), c);
      end else if (r < 85 && live_blocks.size() > 0) begin
        k = $urandom_range(0, live_blocks.size() - 1);
        blk = live_blocks[k];
        live_blocks.delete(k);
        s = int'(blk[PW+CW-1:CW]);
        c = int'(blk[CW-1:0]);
        case ($urandom_range(0, 9))
          0: c = c + 1;
          1: s = s ^ 1;
          2: c = $urandom_range(1, c);
          default: ;
        endcase
        send_req(ACT_FREE, s, c);
      end else if (r < 95) begin
        c = $urandom_range(1, 48);
        if (add_ptr + c <= 16000) begin
          send_req(ACT_ADD, add_ptr, c);
          add_ptr += c;
        end else begin
          send_req(ACT_ADD, $urandom_range(0, POOL - 1), c);
        end
      end else begin
        send_req(2'($urandom_range(0, 3)), $urandom_range(0, POOL - 1),
                 $urandom_range(0, 99) < 50 ? $urandom_range(0, 32767)
                                            : $urandom_range(0, 8));
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
src/bpa_pkg.sv
src/bpa_req_if.sv
src/bpa_rsp_if.sv
src/bpa_dpath.sv
src/bpa_ctrl.sv
src/buddy_page_allocator_core.sv
dv/bpa_checker.sv
dv/testbench.sv
